FILE: design/hig_pkg.sv
// ----------------------------------------------------------------------------
// hig_pkg
// Shared types and constants of the hemisphere index generator.
// ----------------------------------------------------------------------------
package hig_pkg;

	localparam int IDX_W = 17;
	localparam int COR_W = 2;
	localparam int REG_W = 2;
	localparam int CNT_W = 3;
	localparam int CFG_DW = 9;
	localparam int CFG_IW = 2;

	localparam logic [REG_W-1:0] REGION_TOP = 2'd0;
	localparam logic [REG_W-1:0] REGION_BODY = 2'd1;
	localparam logic [REG_W-1:0] REGION_BOTTOM = 2'd2;

	localparam logic [CFG_IW-1:0] CFG_STACK_COUNT = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_SLICE_COUNT = 2'd1;

	localparam logic [CFG_DW-1:0] STACK_COUNT_RST = 9'd8;
	localparam logic [CFG_DW-1:0] SLICE_COUNT_RST = 9'd16;

	typedef struct packed {
		logic [IDX_W-1:0] vertex_index;
		logic [COR_W-1:0] corner;
		logic [REG_W-1:0] region;
		logic             last_index;
	} hig_result_t;

endpackage

FILE: design/hemisphere_index_generator_unit.sv
// ----------------------------------------------------------------------------
// hemisphere_index_generator_unit
// Emits the triangle list indices of a hemisphere mesh, one per input beat.
// ----------------------------------------------------------------------------
// Every input beat carries a restart flag and yields exactly one output beat
// holding a vertex index, its corner within the triangle, the mesh region and
// a flag on the final index of the mesh. A restart beat emits the first index
// again; after the final index the stream wraps on its own.
// Stack and slice counts are written through the configuration channel, which
// is always ready; register 0 is the stack count and register 1 the slice
// count. Writes should only be made while no beat is in flight.
// An accepted input beat is registered at the output, and one beat is
// taken in every cycle while the input does not stall: the counters and
// the single index multiplier sit between the counter and output registers.
// When the receiver stalls, the output register holds its beat and a skid
// entry takes one more; the input stall rises only when that entry is full.
// Reset clears the counters to the first top cap index, empties the output
// stage and restores eight stacks and sixteen slices.
// ----------------------------------------------------------------------------
module hemisphere_index_generator_unit
	import hig_pkg::*;
#(
	parameter int MAX_STACKS = 256,
	parameter int MAX_SLICES = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              restart,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [IDX_W-1:0]  vertex_index,
	output logic [COR_W-1:0]  corner,
	output logic [REG_W-1:0]  region,
	output logic              last_index,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data
);

	logic [CFG_DW-1:0] stack_count_q;
	logic [CFG_DW-1:0] slice_count_q;
	logic              push;
	logic              full;
	hig_result_t       res;
	hig_result_t       res_out;

	assign cfg_ready = 1'b1;
	assign push = in_valid && !in_stall;
	assign in_stall = full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_count_q <= STACK_COUNT_RST;
			slice_count_q <= SLICE_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_STACK_COUNT: stack_count_q <= cfg_data;
				CFG_SLICE_COUNT: slice_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	hig_seq #(
		.MAX_STACKS(MAX_STACKS),
		.MAX_SLICES(MAX_SLICES)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.restart(restart),
		.stack_count(stack_count_q),
		.slice_count(slice_count_q),
		.res(res)
	);

	hig_obuf u_obuf (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.res_in(res),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.full(full),
		.res_out(res_out)
	);

	assign vertex_index = res_out.vertex_index;
	assign corner = res_out.corner;
	assign region = res_out.region;
	assign last_index = res_out.last_index;

endmodule

FILE: design/hig_seq.sv
// ----------------------------------------------------------------------------
// hig_seq
// Region, ring, slice and corner counters with the index arithmetic that
// turns them into one result per accepted beat.
// ----------------------------------------------------------------------------
module hig_seq
	import hig_pkg::*;
#(
	parameter int MAX_STACKS = 256,
	parameter int MAX_SLICES = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic              restart,
	input  logic [CFG_DW-1:0] stack_count,
	input  logic [CFG_DW-1:0] slice_count,
	output hig_result_t       res
);

	localparam int RW = (MAX_STACKS > 2) ? $clog2(MAX_STACKS) : 1;
	localparam int SW = $clog2(MAX_SLICES);
	localparam int CSS = $clog2(MAX_STACKS + 1);
	localparam int CSL = $clog2(MAX_SLICES + 1);
	localparam int KW = CSS + 1;
	localparam int LW = CSL + 1;

	logic [REG_W-1:0] region_q, region_d;
	logic [RW-1:0]    ring_q, ring_d;
	logic [SW-1:0]    slice_q, slice_d;
	logic [CNT_W-1:0] corner_q, corner_d;

	logic [CSS-1:0]   s;
	logic [CSL-1:0]   l;
	logic [LW-1:0]    stride;
	logic [REG_W-1:0] region_eff;
	logic [RW-1:0]    ring_eff;
	logic [SW-1:0]    slice_eff;
	logic [CNT_W-1:0] corner_eff;
	logic [CSS-1:0]   mult;
	logic [IDX_W-1:0] base;
	logic [IDX_W-1:0] a;
	logic [IDX_W-1:0] b;
	logic             slice_end;
	logic             ring_end;

	always_comb begin
		if (stack_count < CFG_DW'(2)) begin
			s = CSS'(2);
		end else if (32'(stack_count) > MAX_STACKS) begin
			s = CSS'(MAX_STACKS);
		end else begin
			s = CSS'(stack_count);
		end
		if (slice_count < CFG_DW'(3)) begin
			l = CSL'(3);
		end else if (32'(slice_count) > MAX_SLICES) begin
			l = CSL'(MAX_SLICES);
		end else begin
			l = CSL'(slice_count);
		end
	end

	always_comb begin
		stride = LW'(l) + LW'(1);
		region_eff = restart ? REGION_TOP : region_q;
		ring_eff = restart ? '0 : ring_q;
		slice_eff = restart ? '0 : slice_q;
		corner_eff = restart ? '0 : corner_q;

		mult = (region_eff == REGION_BOTTOM) ? (s - CSS'(1)) : CSS'(ring_eff);
		base = IDX_W'(mult) * IDX_W'(stride) + IDX_W'(1);
		a = base + IDX_W'(slice_eff);
		b = a + IDX_W'(stride);
		slice_end = (LW'(slice_eff) + LW'(1)) >= LW'(l);
		ring_end = (KW'(ring_eff) + KW'(3)) >= KW'(s);

		region_d = region_eff;
		ring_d = ring_eff;
		slice_d = slice_eff;
		corner_d = corner_eff;
		res.last_index = 1'b0;
		res.vertex_index = '0;
		res.corner = '0;
		res.region = region_eff;

		case (region_eff)
			REGION_BODY: begin
				case (corner_eff)
					3'd0: res.vertex_index = a;
					3'd1: res.vertex_index = a + IDX_W'(1);
					3'd2: res.vertex_index = b;
					3'd3: res.vertex_index = b;
					3'd4: res.vertex_index = a + IDX_W'(1);
					default: res.vertex_index = b + IDX_W'(1);
				endcase
				if (corner_eff >= CNT_W'(3)) begin
					res.corner = (corner_eff - CNT_W'(3) > CNT_W'(2)) ?
						COR_W'(2) : COR_W'(corner_eff - CNT_W'(3));
				end else begin
					res.corner = COR_W'(corner_eff);
				end
				if (corner_eff < CNT_W'(5)) begin
					corner_d = corner_eff + CNT_W'(1);
				end else begin
					corner_d = '0;
					if (slice_end) begin
						slice_d = '0;
						if (ring_end) begin
							ring_d = '0;
							region_d = REGION_BOTTOM;
						end else begin
							ring_d = ring_eff + RW'(1);
						end
					end else begin
						slice_d = slice_eff + SW'(1);
					end
				end
			end
			REGION_BOTTOM: begin
				if (corner_eff == CNT_W'(0)) begin
					res.vertex_index = b - IDX_W'(slice_eff);
				end else if (corner_eff == CNT_W'(1)) begin
					res.vertex_index = a;
				end else begin
					res.vertex_index = a + IDX_W'(1);
				end
				res.corner = (corner_eff > CNT_W'(2)) ? COR_W'(2) : COR_W'(corner_eff);
				if (corner_eff < CNT_W'(2)) begin
					corner_d = corner_eff + CNT_W'(1);
				end else begin
					corner_d = '0;
					if (slice_end) begin
						res.last_index = 1'b1;
						region_d = REGION_TOP;
						ring_d = '0;
						slice_d = '0;
					end else begin
						slice_d = slice_eff + SW'(1);
					end
				end
			end
			default: begin
				res.region = REGION_TOP;
				if (corner_eff == CNT_W'(0)) begin
					res.vertex_index = '0;
				end else if (corner_eff == CNT_W'(1)) begin
					res.vertex_index = IDX_W'(slice_eff) + IDX_W'(2);
				end else begin
					res.vertex_index = IDX_W'(slice_eff) + IDX_W'(1);
				end
				res.corner = (corner_eff > CNT_W'(2)) ? COR_W'(2) : COR_W'(corner_eff);
				if (corner_eff < CNT_W'(2)) begin
					corner_d = corner_eff + CNT_W'(1);
				end else begin
					corner_d = '0;
					ring_d = '0;
					if (slice_end) begin
						slice_d = '0;
						region_d = (s > CSS'(2)) ? REGION_BODY : REGION_BOTTOM;
					end else begin
						slice_d = slice_eff + SW'(1);
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_q <= REGION_TOP;
			ring_q <= '0;
			slice_q <= '0;
			corner_q <= '0;
		end else if (push) begin
			region_q <= region_d;
			ring_q <= ring_d;
			slice_q <= slice_d;
			corner_q <= corner_d;
		end
	end

endmodule

FILE: design/hig_obuf.sv
// ----------------------------------------------------------------------------
// hig_obuf
// Output register with a skid entry, so that a new beat can be taken while
// the receiver holds the current one.
// ----------------------------------------------------------------------------
module hig_obuf
	import hig_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  hig_result_t res_in,
	input  logic        out_stall,
	output logic        out_valid,
	output logic        full,
	output hig_result_t res_out
);

	logic        main_valid_q;
	logic        skid_valid_q;
	hig_result_t main_q;
	hig_result_t skid_q;
	logic        pop;

	assign pop = main_valid_q && !out_stall;
	assign out_valid = main_valid_q;
	assign full = skid_valid_q;
	assign res_out = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (main_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end
			main_valid_q <= 1'b1;
		end else if (pop) begin
			main_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				main_q <= skid_q;
			end
		end else if (push) begin
			if (main_valid_q && !pop) begin
				skid_q <= res_in;
			end else begin
				main_q <= res_in;
			end
		end
	end

endmodule

FILE: design/hig_checker.sv
// ----------------------------------------------------------------------------
// hig_checker
// Port-level checks of the hemisphere index generator, bound to the top level.
// ----------------------------------------------------------------------------
module hig_checker
	import hig_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [IDX_W-1:0]  vertex_index,
	input logic [COR_W-1:0]  corner,
	input logic [REG_W-1:0]  region,
	input logic              last_index
);

	// The input side only stalls once a beat is already waiting at the output.
	a_stall_needs_output: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no output beat pending");

	a_accept_to_output: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !out_valid) |=> out_valid)
		else $error("accepted beat did not reach the output");

	a_output_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(vertex_index)
			&& $stable(corner) && $stable(region) && $stable(last_index)))
		else $error("stalled output beat changed");

	// The final index is always the third corner of a bottom cap triangle.
	a_last_in_bottom: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_index) |-> (region == REGION_BOTTOM && corner == 2'd2))
		else $error("final index outside the bottom cap");

endmodule

bind hemisphere_index_generator_unit hig_checker u_hig_checker (.*);

FILE: tb/hemisphere_index_generator_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hemisphere_index_generator_unit_test
// Checks the index stream of the hemisphere mesh generator against a predictor.
// ----------------------------------------------------------------------------
// Phases of restart and advance beats are queued and sent in random bursts.
// Between phases, once every expected beat has arrived, the stack and slice
// counts are rewritten, in the random phases not always. Settings include out
// of range, minimum and maximum values, and shrinks that leave the counters
// beyond the new bounds. Each accepted input beat is run through a predictor
// of the mesh walk. Every output beat is compared field by field with the
// oldest prediction, while the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module hemisphere_index_generator_unit_test;
	import hig_pkg::*;

	localparam int MAX_STACKS = 256;
	localparam int MAX_SLICES = 256;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_BEATS = 1000;
	localparam logic [CFG_IW-1:0] CFG_UNUSED_INDEX = 2'd3;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              restart = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [IDX_W-1:0]  vertex_index;
	logic [COR_W-1:0]  corner;
	logic [REG_W-1:0]  region;
	logic              last_index;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CFG_IW-1:0] cfg_index = '0;
	logic [CFG_DW-1:0] cfg_data = '0;

	logic [CFG_DW-1:0] stack_cfg = STACK_COUNT_RST;
	logic [CFG_DW-1:0] slice_cfg = SLICE_COUNT_RST;
	logic [REG_W-1:0]  region_q = REGION_TOP;
	int unsigned       ring_q = 0;
	int unsigned       slice_q = 0;
	int unsigned       corner_q = 0;

	bit                pending_restarts[$];
	hig_result_t       expected_indices[$];
	int                unsent_beats = 0;
	int                mismatch_count = 0;
	int                idle_cycles = 0;
	logic              in_taken = 1'b0;
	int                burst_left = 0;
	int                gap_left = 0;
	int                stall_hold = 0;
	int                stall_mode = 0;
	logic [7:0]        stall_pattern = '0;

	hemisphere_index_generator_unit #(
		.MAX_STACKS(MAX_STACKS),
		.MAX_SLICES(MAX_SLICES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.restart(restart),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.vertex_index(vertex_index),
		.corner(corner),
		.region(region),
		.last_index(last_index),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void rewind_mesh();
		region_q = REGION_TOP;
		ring_q = 0;
		slice_q = 0;
		corner_q = 0;
	endfunction

	// Walks the mesh by one corner and returns the beat that it emits.
	function automatic hig_result_t next_corner_index(input logic restart_bit);
		int unsigned s, l, stride, a, b, centre, rim, idx, cor;
		logic [REG_W-1:0] rgn;
		logic last;
		hig_result_t r;
		s = (stack_cfg < 2) ? 2 : ((stack_cfg > MAX_STACKS) ? MAX_STACKS : stack_cfg);
		l = (slice_cfg < 3) ? 3 : ((slice_cfg > MAX_SLICES) ? MAX_SLICES : slice_cfg);
		stride = l + 1;
		idx = 0;
		cor = 0;
		last = 1'b0;
		if (restart_bit)
			rewind_mesh();
		rgn = region_q;
		if (rgn == REGION_BODY) begin
			a = 1 + ring_q * stride + slice_q;
			b = a + stride;
			case (corner_q)
				0: idx = a;
				1: idx = a + 1;
				2, 3: idx = b;
				4: idx = a + 1;
				default: idx = b + 1;
			endcase
			cor = (corner_q >= 3) ? corner_q - 3 : corner_q;
			if (cor > 2)
				cor = 2;
			if (corner_q < 5) begin
				corner_q++;
			end else begin
				corner_q = 0;
				if (slice_q + 1 >= l) begin
					slice_q = 0;
					if (ring_q + 3 >= s) begin
						ring_q = 0;
						region_q = REGION_BOTTOM;
					end else begin
						ring_q++;
					end
				end else begin
					slice_q++;
				end
			end
		end else if (rgn == REGION_BOTTOM) begin
			centre = s * stride + 1;
			rim = centre - stride;
			if (corner_q == 0)
				idx = centre;
			else if (corner_q == 1)
				idx = rim + slice_q;
			else
				idx = rim + slice_q + 1;
			cor = (corner_q > 2) ? 2 : corner_q;
			if (corner_q < 2) begin
				corner_q++;
			end else begin
				corner_q = 0;
				if (slice_q + 1 >= l) begin
					last = 1'b1;
					rewind_mesh();
				end else begin
					slice_q++;
				end
			end
		end else begin
			rgn = REGION_TOP;
			if (corner_q == 0)
				idx = 0;
			else if (corner_q == 1)
				idx = slice_q + 2;
			else
				idx = slice_q + 1;
			cor = (corner_q > 2) ? 2 : corner_q;
			if (corner_q < 2) begin
				corner_q++;
			end else begin
				corner_q = 0;
				ring_q = 0;
				if (slice_q + 1 >= l) begin
					slice_q = 0;
					region_q = (s > 2) ? REGION_BODY : REGION_BOTTOM;
				end else begin
					slice_q++;
				end
			end
		end
		r.vertex_index = idx[IDX_W-1:0];
		r.corner = cor[COR_W-1:0];
		r.region = rgn;
		r.last_index = last;
		return r;
	endfunction

	function automatic logic [CFG_DW-1:0] pick_count(input int floor_small, input int ceil_small);
		int v;
		case ($urandom_range(0, 9))
			0: v = $urandom_range(0, floor_small - 1);
			1: v = $urandom_range(200, 511);
			default: v = $urandom_range(floor_small, ceil_small);
		endcase
		return v[CFG_DW-1:0];
	endfunction

	task automatic write_register(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			CFG_STACK_COUNT: stack_cfg = val;
			CFG_SLICE_COUNT: slice_cfg = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic queue_beats(input int count, input int restart_odds, input bit lead_restart);
		bit r;
		for (int i = 0; i < count; i++) begin
			if (i == 0 && lead_restart)
				r = 1'b1;
			else
				r = (restart_odds != 0) && ($urandom_range(1, restart_odds) == 1);
			pending_restarts = {pending_restarts, r};
		end
		unsent_beats += count;
	endtask

	task automatic settle();
		while (unsent_beats != 0 || expected_indices.size() != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (gap_left != 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_restarts.size() != 0) begin
				in_valid <= 1'b1;
				restart <= pending_restarts.pop_front();
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 48);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (stall_hold == 0) begin
				stall_mode = $urandom_range(0, 2);
				stall_pattern = 8'($urandom);
				stall_hold = $urandom_range(30, 200);
			end else begin
				stall_hold--;
			end
			stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= stall_pattern[0];
				default: out_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	always @(posedge clk) begin : monitor
		hig_result_t want;
		in_taken <= in_valid && !in_stall;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_indices = {expected_indices, next_corner_index(restart)};
				unsent_beats--;
			end
			if (out_valid && !out_stall) begin
				if (expected_indices.size() == 0) begin
					$error("output beat with no prediction waiting: vertex_index %0d", vertex_index);
					mismatch_count++;
				end else begin
					want = expected_indices.pop_front();
					if (vertex_index !== want.vertex_index) begin
						$error("vertex_index: expected %0d, actual %0d", want.vertex_index,
							vertex_index);
						mismatch_count++;
					end
					if (corner !== want.corner) begin
						$error("corner: expected %0d, actual %0d", want.corner, corner);
						mismatch_count++;
					end
					if (region !== want.region) begin
						$error("region: expected %0d, actual %0d", want.region, region);
						mismatch_count++;
					end
					if (last_index !== want.last_index) begin
						$error("last_index: expected %0d, actual %0d", want.last_index,
							last_index);
						mismatch_count++;
					end
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("SCOREBOARD MISMATCH");
					$finish;
				end
			end
		end
	end

	initial begin : stimulus
		int sent;
		int n;
		int odds;
		logic [CFG_DW-1:0] stacks;
		logic [CFG_DW-1:0] slices;
		rewind_mesh();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings first, then two stacks and three slices reached
		// through clamping, run past the final index so that the stream wraps.
		queue_beats(6, 0, 1'b1);
		settle();
		write_register(CFG_STACK_COUNT, 9'd0);
		write_register(CFG_SLICE_COUNT, 9'd1);
		write_register(CFG_UNUSED_INDEX, '1);
		queue_beats(19, 0, 1'b1);
		settle();

		sent = 0;
		for (int phase = 0; sent < RANDOM_BEATS; phase++) begin
			case (phase)
				0: begin stacks = 9'd256; slices = 9'd256; end
				1: begin stacks = 9'd511; slices = 9'd2; end
				2: begin stacks = 9'd3; slices = 9'd511; end
				3: begin stacks = 9'd3; slices = 9'd3; end
				default: begin
					stacks = pick_count(2, 6);
					slices = pick_count(3, 8);
				end
			endcase
			if (phase < 4 || $urandom_range(0, 3) != 0)
				write_register(CFG_STACK_COUNT, stacks);
			if (phase < 4 || $urandom_range(0, 3) != 0)
				write_register(CFG_SLICE_COUNT, slices);
			n = $urandom_range(40, 160);
			odds = ($urandom_range(0, 7) == 0) ? 3 : 80;
			queue_beats(n, odds, 1'($urandom_range(0, 1)));
			settle();
			sent += n;
		end

		repeat (4) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
